>>> rtl/core/kruskal_mst_weight_defines.svh
// ----------------------------------------------------------------------------
// kruskal_mst_weight_defines
// Assertion macros for the minimum spanning forest weight engine.
// ----------------------------------------------------------------------------
`ifndef KRUSKAL_MST_WEIGHT_DEFINES_SVH
`define KRUSKAL_MST_WEIGHT_DEFINES_SVH

// Check an overlapping implication, disabled during reset.
`define KMW_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Check a next-cycle implication, disabled during reset.
`define KMW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// Check a next-cycle implication that also holds across reset.
`define KMW_ASSERT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/core/kmw_pkg.sv
// ----------------------------------------------------------------------------
// kmw_pkg
// Shared types and constants of the minimum spanning forest weight engine.
// ----------------------------------------------------------------------------
package kmw_pkg;

   localparam int DEF_MAX_NODES   = 1024;
   localparam int DEF_MAX_EDGES   = 4096;
   localparam int DEF_WEIGHT_BITS = 16;

   localparam int NODE_COUNT_BITS = 11;
   localparam logic [NODE_COUNT_BITS-1:0] NODE_COUNT_RESET = 11'd1024;
   localparam int RANK_BITS   = 4;
   localparam int SUM_BITS    = 27;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [9:0]  end_a;
      logic [9:0]  end_b;
      logic [15:0] edge_weight;
      logic        last_edge;
   } req_type;

   typedef struct packed {
      logic [25:0] tree_weight;
      logic [9:0]  tree_edges;
      logic        dropped_flag;
   } rsp_type;

   // Classified edge handed from front to back.
   typedef struct packed {
      req_type item;
      logic    keep;
      logic    drop;
   } qent_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_CLEAR,
      ST_SCAN,
      ST_EDGE,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_COMP_RD,
      ST_COMP_CHK,
      ST_LINK,
      ST_LINK2,
      ST_OUT
   } state_type;

endpackage

>>> rtl/core/kmw_queue.sv
// ----------------------------------------------------------------------------
// kmw_queue
// Short FIFO of classified edges between the front and back parts.
// ----------------------------------------------------------------------------
module kmw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  kmw_pkg::qent_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output kmw_pkg::qent_type pop_data
);
   import kmw_pkg::*;

   qent_type               mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wp_ff, wp_in, rp_ff, rp_in;
   logic [QPTR_BITS:0]     cnt_ff, cnt_in;
   logic                   do_push, do_pop;

   assign push_ready = (cnt_ff != (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = mem_ff[rp_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and occupancy.
   always_comb begin
      wp_in  = do_push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = do_pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (QPTR_BITS+1)'(do_push) - (QPTR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Hold entries.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wp_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/kmw_front.sv
// ----------------------------------------------------------------------------
// kmw_front
// Accepts edge beats, flags bad endpoints and a full store, drops self-loops.
// ----------------------------------------------------------------------------
module kmw_front #(
   parameter int MAX_EDGES = kmw_pkg::DEF_MAX_EDGES
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [kmw_pkg::NODE_COUNT_BITS-1:0]  eff_nodes,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  kmw_pkg::req_type                     req,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output kmw_pkg::qent_type                    push_data
);
   import kmw_pkg::*;

   localparam int ECNT = $clog2(MAX_EDGES + 1);

   logic [ECNT-1:0] count_ff, count_in;
   logic            bad, full, keep;

   // Classify the edge against node count and store occupancy.
   always_comb begin
      bad  = ({1'b0, req.end_a} >= eff_nodes) || ({1'b0, req.end_b} >= eff_nodes);
      full = (count_ff == ECNT'(MAX_EDGES));
      keep = !bad && !full && (req.end_a != req.end_b);
      push_data.item = req;
      push_data.keep = keep;
      push_data.drop = bad || full;
   end

   assign push_valid = req_valid;
   assign req_ready  = push_ready;

   // Count stored edges of the current graph; restart after the last one.
   always_comb begin
      count_in = count_ff;
      if (req_valid && push_ready) begin
         if (req.last_edge) begin
            count_in = '0;
         end else if (keep) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/core/kmw_back.sv
// ----------------------------------------------------------------------------
// kmw_back
// Stores edges, then runs weight-ordered passes with union-find and reports.
// ----------------------------------------------------------------------------
module kmw_back #(
   parameter int MAX_NODES   = kmw_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES   = kmw_pkg::DEF_MAX_EDGES,
   parameter int WEIGHT_BITS = kmw_pkg::DEF_WEIGHT_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [kmw_pkg::NODE_COUNT_BITS-1:0]  eff_nodes,
   input  logic                                 pop_valid,
   output logic                                 pop_ready,
   input  kmw_pkg::qent_type                    pop_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output kmw_pkg::rsp_type                     rsp
);
   import kmw_pkg::*;

   localparam int NIDX = $clog2(MAX_NODES);
   localparam int EIDX = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECNT = $clog2(MAX_EDGES + 1);
   localparam int SW   = 2 * NIDX + WEIGHT_BITS;
   localparam int UW   = RANK_BITS + NIDX;

   // Memories.
   logic [SW-1:0] store_mem [MAX_EDGES];
   logic [UW-1:0] uf_mem    [MAX_NODES];
   logic [SW-1:0] store_q;
   logic [UW-1:0] uf_q;

   logic            store_we, store_re, uf_we;
   logic [EIDX-1:0] store_waddr, store_raddr;
   logic [SW-1:0]   store_wdata;
   logic [NIDX-1:0] uf_waddr, uf_raddr;
   logic [UW-1:0]   uf_wdata;

   state_type                state_ff, state_in;
   logic [ECNT-1:0]          cnt_ff, cnt_in, idx_ff, idx_in;
   logic [NIDX-1:0]          clr_ff, clr_in, x_ff, x_in;
   logic [NIDX-1:0]          ra_ff, ra_in, rb_ff, rb_in;
   logic [RANK_BITS-1:0]     rka_ff, rka_in, rkb_ff, rkb_in;
   logic [NIDX-1:0]          taken_ff, taken_in;
   logic [SUM_BITS-1:0]      sum_ff, sum_in;
   logic [WEIGHT_BITS-1:0]   cur_ff, cur_in, next_ff, next_in, min_ff, min_in;
   logic                     has_next_ff, has_next_in, any_ff, any_in;
   logic                     drop_ff, drop_in, side_ff, side_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   logic [NIDX-1:0]          ea, eb, uf_par, root;
   logic [WEIGHT_BITS-1:0]   ew, in_w;
   logic [RANK_BITS-1:0]     uf_rank;
   logic                     done;

   assign ea      = store_q[SW-1 -: NIDX];
   assign eb      = store_q[NIDX+WEIGHT_BITS-1 -: NIDX];
   assign ew      = store_q[WEIGHT_BITS-1:0];
   assign uf_par  = uf_q[NIDX-1:0];
   assign uf_rank = uf_q[UW-1 -: RANK_BITS];
   assign in_w    = WEIGHT_BITS'(pop_data.item.edge_weight);
   assign root    = side_ff ? rb_ff : ra_ff;
   assign done    = (int'(taken_ff) + 1) == int'(eff_nodes);

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      clr_in       = clr_ff;
      x_in         = x_ff;
      ra_in        = ra_ff;
      rb_in        = rb_ff;
      rka_in       = rka_ff;
      rkb_in       = rkb_ff;
      taken_in     = taken_ff;
      sum_in       = sum_ff;
      cur_in       = cur_ff;
      next_in      = next_ff;
      min_in       = min_ff;
      has_next_in  = has_next_ff;
      any_in       = any_ff;
      drop_in      = drop_ff;
      side_in      = side_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      pop_ready    = 1'b0;
      store_we     = 1'b0;
      store_waddr  = cnt_ff[EIDX-1:0];
      store_wdata  = {NIDX'(pop_data.item.end_a), NIDX'(pop_data.item.end_b), in_w};
      store_re     = 1'b0;
      store_raddr  = idx_ff[EIDX-1:0];
      uf_we        = 1'b0;
      uf_waddr     = clr_ff;
      uf_wdata     = {RANK_BITS'(0), clr_ff};
      uf_raddr     = x_ff;

      case (state_ff)
         // Take classified edges into the store.
         ST_LOAD: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               drop_in = drop_ff || pop_data.drop;
               if (pop_data.keep) begin
                  store_we = 1'b1;
                  cnt_in   = cnt_ff + 1'b1;
                  any_in   = 1'b1;
                  if (!any_ff || (in_w < min_ff)) begin
                     min_in = in_w;
                  end
               end
               if (pop_data.item.last_edge) begin
                  clr_in   = '0;
                  state_in = ST_CLEAR;
               end
            end
         end
         // Reset the forest: parent to self, rank to zero.
         ST_CLEAR: begin
            uf_we  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == NIDX'(MAX_NODES - 1)) begin
               cur_in      = min_ff;
               has_next_in = 1'b0;
               idx_in      = '0;
               sum_in      = '0;
               taken_in    = '0;
               state_in    = ST_SCAN;
            end
         end
         // Walk the store; at pass end move to the next weight.
         ST_SCAN: begin
            if (done) begin
               state_in = ST_OUT;
            end else if (idx_ff == cnt_ff) begin
               if (has_next_ff) begin
                  cur_in      = next_ff;
                  has_next_in = 1'b0;
                  idx_in      = '0;
               end else begin
                  state_in = ST_OUT;
               end
            end else begin
               store_re = 1'b1;
               state_in = ST_EDGE;
            end
         end
         // Track the next weight; process edges of the current one.
         ST_EDGE: begin
            if ((ew > cur_ff) && (!has_next_ff || (ew < next_ff))) begin
               next_in     = ew;
               has_next_in = 1'b1;
            end
            if (ew == cur_ff) begin
               side_in  = 1'b0;
               x_in     = ea;
               state_in = ST_FIND_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_FIND_RD: begin
            state_in = ST_FIND_CHK;
         end
         // Follow parents up to the root.
         ST_FIND_CHK: begin
            if (uf_par == x_ff) begin
               if (side_ff) begin
                  rb_in  = x_ff;
                  rkb_in = uf_rank;
                  x_in   = eb;
               end else begin
                  ra_in  = x_ff;
                  rka_in = uf_rank;
                  x_in   = ea;
               end
               state_in = ST_COMP_RD;
            end else begin
               x_in     = uf_par;
               state_in = ST_FIND_RD;
            end
         end
         ST_COMP_RD: begin
            state_in = ST_COMP_CHK;
         end
         // Point each node on the path straight at the root.
         ST_COMP_CHK: begin
            if ((x_ff == root) || (uf_par == root)) begin
               if (side_ff) begin
                  state_in = ST_LINK;
               end else begin
                  side_in  = 1'b1;
                  x_in     = eb;
                  state_in = ST_FIND_RD;
               end
            end else begin
               uf_we    = 1'b1;
               uf_waddr = x_ff;
               uf_wdata = {uf_rank, root};
               x_in     = uf_par;
               state_in = ST_COMP_RD;
            end
         end
         // Join the two trees by rank and count the edge.
         ST_LINK: begin
            idx_in   = idx_ff + 1'b1;
            state_in = ST_SCAN;
            if (ra_ff != rb_ff) begin
               uf_we    = 1'b1;
               taken_in = taken_ff + 1'b1;
               sum_in   = sum_ff + SUM_BITS'(ew);
               if (rka_ff < rkb_ff) begin
                  uf_waddr = ra_ff;
                  uf_wdata = {rka_ff, rb_ff};
               end else begin
                  uf_waddr = rb_ff;
                  uf_wdata = {rkb_ff, ra_ff};
                  if (rka_ff == rkb_ff) begin
                     idx_in   = idx_ff;
                     state_in = ST_LINK2;
                  end
               end
            end
         end
         // Raise the rank of the surviving root.
         ST_LINK2: begin
            uf_we    = 1'b1;
            uf_waddr = ra_ff;
            uf_wdata = {rka_ff + 1'b1, ra_ff};
            idx_in   = idx_ff + 1'b1;
            state_in = ST_SCAN;
         end
         // Load the result register once it is free.
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.tree_weight  = sum_ff[25:0];
               rsp_in.tree_edges   = 10'(taken_ff);
               rsp_in.dropped_flag = drop_ff;
               cnt_in              = '0;
               drop_in             = 1'b0;
               any_in              = 1'b0;
               state_in            = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         cnt_ff       <= '0;
         drop_ff      <= 1'b0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         drop_ff      <= drop_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      clr_ff      <= clr_in;
      x_ff        <= x_in;
      ra_ff       <= ra_in;
      rb_ff       <= rb_in;
      rka_ff      <= rka_in;
      rkb_ff      <= rkb_in;
      taken_ff    <= taken_in;
      sum_ff      <= sum_in;
      cur_ff      <= cur_in;
      next_ff     <= next_in;
      min_ff      <= min_in;
      has_next_ff <= has_next_in;
      side_ff     <= side_in;
      rsp_ff      <= rsp_in;
   end

   // Edge store.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= store_wdata;
      end
      if (store_re) begin
         store_q <= store_mem[store_raddr];
      end
   end

   // Parent and rank table.
   always_ff @(posedge clock) begin
      if (uf_we) begin
         uf_mem[uf_waddr] <= uf_wdata;
      end
      uf_q <= uf_mem[uf_raddr];
   end

endmodule

>>> rtl/core/kruskal_mst_weight.sv
// ----------------------------------------------------------------------------
// kruskal_mst_weight
// Minimum spanning forest weight engine over a stream of weighted edges.
// ----------------------------------------------------------------------------
// Usage:
//   Write node_count on the csr_ channel while idle (always ready).
//   Send edges on req_, one beat each; last_edge closes the graph.
//   Edges load at one beat per cycle, unless the queue is full, into the
//   edge store through a four-entry queue, so the front keeps taking beats
//   while the back works. After the last beat the back clears the parent/rank
//   table, then makes one pass over the store per distinct weight until
//   node_count-1 edges are taken or no heavier weight is left. Each stored
//   edge is read in turn; for an edge of the pass weight a find and a
//   compression walk run on each end, then the trees are linked, with a second
//   table write when equal ranks raise the surviving root. One rsp_ beat
//   carries the forest weight, edge count and drop flag.
//   A stalled rsp_ holds its beat; the back waits for the slot, and the req_
//   side stalls once the queue fills.
//   Reset empties the queue and the store and sets node_count to 1024.
// ----------------------------------------------------------------------------
module kruskal_mst_weight #(
   parameter int MAX_NODES   = kmw_pkg::DEF_MAX_NODES,
   parameter int MAX_EDGES   = kmw_pkg::DEF_MAX_EDGES,
   parameter int WEIGHT_BITS = kmw_pkg::DEF_WEIGHT_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kmw_pkg::NODE_COUNT_BITS-1:0] csr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  kmw_pkg::req_type                    req,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output kmw_pkg::rsp_type                    rsp
);
   import kmw_pkg::*;

   logic [NODE_COUNT_BITS-1:0] node_count_ff, node_count_in, eff_nodes;
   logic                       push_valid, push_ready, pop_valid, pop_ready;
   qent_type                   push_data, pop_data;

   // Node count register, clamped to the table size.
   assign csr_ready     = 1'b1;
   assign node_count_in = csr_valid ? csr_data : node_count_ff;
   assign eff_nodes     = (int'(node_count_ff) > MAX_NODES) ?
                          NODE_COUNT_BITS'(MAX_NODES) : node_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   kmw_front #(.MAX_EDGES(MAX_EDGES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .eff_nodes  (eff_nodes),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   kmw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   kmw_back #(
      .MAX_NODES   (MAX_NODES),
      .MAX_EDGES   (MAX_EDGES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .eff_nodes (eff_nodes),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

endmodule

>>> rtl/core/kmw_checker.sv
// ----------------------------------------------------------------------------
// kmw_sva_checker
// Port-level checks on the result channel of the spanning forest engine.
// ----------------------------------------------------------------------------
`include "kruskal_mst_weight_defines.svh"

module kmw_sva_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input kmw_pkg::rsp_type rsp
);
   import kmw_pkg::*;

   logic rsp_stall, no_edges;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign no_edges  = rsp_valid && (rsp.tree_edges == '0);

   // A stalled result beat holds.
   `KMW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp))

   // No tree edges means no weight.
   `KMW_ASSERT_SAME(a_empty_zero, clock, reset, no_edges, rsp.tree_weight == '0)

   // Reset leaves no result pending.
   `KMW_ASSERT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid)

endmodule

bind kruskal_mst_weight kmw_sva_checker u_kmw_sva_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);

>>> verif/kmw_checker.sv
// ----------------------------------------------------------------------------
// kmw_checker
// Watches the csr_, req_ and rsp_ channels of the spanning forest engine,
// predicts each forest result on the closing edge and compares every rsp_
// beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module kmw_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [kmw_pkg::NODE_COUNT_BITS-1:0] csr_data,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  kmw_pkg::req_type                    req,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  kmw_pkg::rsp_type                    rsp,
   output int                                  fail_count,
   output int                                  pending_results
);
   timeunit 1ns;
   timeprecision 1ps;
   import kmw_pkg::*;

   localparam int NODES = DEF_MAX_NODES;
   localparam int EDGES = DEF_MAX_EDGES;

   logic [NODE_COUNT_BITS-1:0] node_setting;
   logic [9:0]  held_a [EDGES];
   logic [9:0]  held_b [EDGES];
   logic [15:0] held_w [EDGES];
   int          held_total;
   logic        drop_pending;
   int          forest_up [NODES];
   int          forest_rank [NODES];
   int          scan_order [EDGES];
   rsp_type     forest_q [$];

   // Follow parents to the root, then point the walked path at it.
   function automatic int forest_root(int x);
      int r;
      int nx;
      r = x;
      while (forest_up[r] != r) r = forest_up[r];
      while (forest_up[x] != r) begin
         nx = forest_up[x];
         forest_up[x] = r;
         x = nx;
      end
      return r;
   endfunction

   // Sort held edges by weight, then join trees until the forest is full.
   function automatic rsp_type forest_result(int nodes);
      rsp_type    res;
      int         i;
      int         j;
      int         t;
      int         ra;
      int         rb;
      logic [26:0] sum;
      int         taken;
      for (i = 0; i < NODES; i++) begin
         forest_up[i] = i;
         forest_rank[i] = 0;
      end
      for (i = 0; i < held_total; i++) begin
         t = i;
         j = i;
         while (j > 0 && held_w[scan_order[j-1]] > held_w[t]) begin
            scan_order[j] = scan_order[j-1];
            j--;
         end
         scan_order[j] = t;
      end
      sum = '0;
      taken = 0;
      for (i = 0; i < held_total; i++) begin
         if (nodes == 0 || taken >= nodes - 1) break;
         t = scan_order[i];
         ra = forest_root(held_a[t]);
         rb = forest_root(held_b[t]);
         if (ra != rb) begin
            if (forest_rank[ra] < forest_rank[rb]) begin
               j = ra;
               ra = rb;
               rb = j;
            end
            forest_up[rb] = ra;
            if (forest_rank[ra] == forest_rank[rb])
               forest_rank[ra] = (forest_rank[ra] + 1) & 15;
            sum = sum + held_w[t];
            taken++;
         end
      end
      res.tree_weight  = sum[25:0];
      res.tree_edges   = taken[9:0];
      res.dropped_flag = drop_pending;
      return res;
   endfunction

   // Track config, load edges and compare results on accepted beats.
   always @(posedge clock) begin
      int      nodes;
      rsp_type want;
      int      errs;
      if (reset) begin
         node_setting    <= NODE_COUNT_RESET;
         held_total      = 0;
         drop_pending    = 1'b0;
         forest_q.delete();
         fail_count      <= 0;
         pending_results <= 0;
      end else begin
         errs = 0;
         if (csr_valid && csr_ready) node_setting <= csr_data;
         if (req_valid && req_ready) begin
            nodes = (node_setting > NODES) ? NODES : node_setting;
            if (req.end_a >= nodes || req.end_b >= nodes || held_total >= EDGES) begin
               drop_pending = 1'b1;
            end else if (req.end_a != req.end_b) begin
               held_a[held_total] = req.end_a;
               held_b[held_total] = req.end_b;
               held_w[held_total] = req.edge_weight;
               held_total++;
            end
            if (req.last_edge) begin
               forest_q     = {forest_q, forest_result(nodes)};
               held_total   = 0;
               drop_pending = 1'b0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (forest_q.size() == 0) begin
               $error("rsp beat with no result pending");
               errs++;
            end else begin
               want = forest_q.pop_front();
               if (rsp.tree_weight !== want.tree_weight) begin
                  $error("tree_weight expected %0d actual %0d",
                         want.tree_weight, rsp.tree_weight);
                  errs++;
               end
               if (rsp.tree_edges !== want.tree_edges) begin
                  $error("tree_edges expected %0d actual %0d",
                         want.tree_edges, rsp.tree_edges);
                  errs++;
               end
               if (rsp.dropped_flag !== want.dropped_flag) begin
                  $error("dropped_flag expected %0d actual %0d",
                         want.dropped_flag, rsp.dropped_flag);
                  errs++;
               end
            end
         end
         fail_count      <= fail_count + errs;
         pending_results <= forest_q.size();
      end
   end

endmodule

>>> verif/tb_kruskal_mst_weight.sv
// ----------------------------------------------------------------------------
// tb_kruskal_mst_weight
// Drives edge graphs and node_count settings into the spanning forest engine
// under random sender and receiver stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_kruskal_mst_weight;
   timeunit 1ns;
   timeprecision 1ps;
   import kmw_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;

   logic                       clock;
   logic                       reset;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [NODE_COUNT_BITS-1:0] csr_data;
   logic                       req_valid;
   logic                       req_ready;
   req_type                    req;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   rsp_type                    rsp;
   int                         fail_count;
   int                         pending_results;
   int                         send_idle;
   int                         recv_idle;
   int                         cycle_count = 0;
   int                         node_limit;

   kruskal_mst_weight u_top (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   kmw_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req             (req),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp             (rsp),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   // Free-running clock.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Stall the receiver at random.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL kruskal_mst_weight");
         $finish;
      end
   end

   // Send one edge beat; valid stays high afterwards until the next call.
   task automatic send_edge(input logic [9:0] a, input logic [9:0] b,
                            input logic [15:0] w, input logic last);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req.end_a      <= a;
      req.end_b      <= b;
      req.edge_weight <= w;
      req.last_edge  <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Wait for all results, let the back settle, then write node_count.
   task automatic set_nodes(input logic [NODE_COUNT_BITS-1:0] v);
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      node_limit = (v > DEF_MAX_NODES) ? DEF_MAX_NODES : v;
   endtask

   // Random graph: mostly in-range edges, some noise endpoints and self-loops.
   task automatic send_graph(input int len);
      logic [9:0]  a;
      logic [9:0]  b;
      logic [15:0] w;
      for (int i = 0; i < len; i++) begin
         if (node_limit == 0 || $urandom_range(99) < 8) begin
            a = 10'($urandom_range(1023));
            b = 10'($urandom_range(1023));
         end else begin
            a = 10'($urandom_range(node_limit - 1));
            b = ($urandom_range(99) < 5) ? a : 10'($urandom_range(node_limit - 1));
         end
         w = ($urandom_range(99) < 20) ? 16'($urandom_range(65535)) :
                                         16'($urandom_range(7));
         send_edge(a, b, w, i == len - 1);
      end
   endtask

   initial begin
      int cfg_pick;
      clock       = 1'b1;
      reset       = 1'b1;
      csr_valid   = 1'b0;
      csr_data    = '0;
      req_valid   = 1'b0;
      req         = '0;
      send_idle   = 12;
      recv_idle   = 81;
      node_limit  = DEF_MAX_NODES;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: extreme endpoints and weights, repeated edge, self-loop.
      send_edge(10'd0, 10'd1023, 16'hFFFF, 1'b0);
      send_edge(10'd1023, 10'd0, 16'h0000, 1'b0);
      send_edge(10'd5, 10'd5, 16'h0007, 1'b0);
      send_edge(10'd512, 10'd511, 16'h8000, 1'b1);
      // Graph closed by a lone self-loop.
      send_edge(10'd3, 10'd3, 16'h0001, 1'b1);
      // Small graph with a bad endpoint; stop once the forest spans all four nodes.
      set_nodes(11'd4);
      send_edge(10'd7, 10'd1, 16'h0002, 1'b0);
      send_edge(10'd0, 10'd1, 16'h0009, 1'b0);
      send_edge(10'd1, 10'd2, 16'h0003, 1'b0);
      send_edge(10'd2, 10'd3, 16'h0001, 1'b0);
      send_edge(10'd0, 10'd3, 16'h0004, 1'b1);
      // Zero nodes drops everything.
      set_nodes(11'd0);
      send_edge(10'd0, 10'd0, 16'h0001, 1'b0);
      send_edge(10'd0, 10'd1, 16'h0001, 1'b1);
      // One node: a self-loop is in range.
      set_nodes(11'd1);
      send_edge(10'd0, 10'd0, 16'h0005, 1'b0);
      send_edge(10'd0, 10'd1, 16'h0005, 1'b1);
      // Oversized node count clamps to the maximum; send a chain.
      set_nodes(11'd2047);
      for (int i = 0; i < 40; i++)
         send_edge(10'(i), 10'(i + 1), 16'h0001, i == 39);

      // Random graphs over three stall profiles.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 12 : (ph == 1) ? 81 : 0;
         recv_idle = (ph == 0) ? 81 : (ph == 1) ? 12 : 0;
         for (int c = 0; c < 3; c++) begin
            cfg_pick = $urandom_range(4);
            case (cfg_pick)
               0: set_nodes(11'd1024);
               1: set_nodes(11'd2);
               2: set_nodes(NODE_COUNT_BITS'($urandom_range(3, 64)));
               3: set_nodes(NODE_COUNT_BITS'($urandom_range(2047)));
               default: set_nodes(NODE_COUNT_BITS'($urandom_range(1024, 2047)));
            endcase
            for (int g = 0; g < 5; g++) begin
               send_graph($urandom_range(1, 14));
               // Hold off the sender until the results drain.
               if (g == 2) begin
                  req_valid <= 1'b0;
                  @(negedge clock);
                  while (pending_results != 0) @(negedge clock);
               end
            end
         end
      end

      req_valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0) begin
         $display("PASS kruskal_mst_weight");
      end else begin
         $display("FAIL kruskal_mst_weight");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/kmw_pkg.sv
rtl/core/kmw_queue.sv
rtl/core/kmw_front.sv
rtl/core/kmw_back.sv
rtl/core/kruskal_mst_weight.sv
rtl/core/kmw_checker.sv
verif/kmw_checker.sv
verif/tb_kruskal_mst_weight.sv
